>>> src/qbt_pkg.sv
// ============================================================================
// Quadratic curve tessellator package
// Shared constants and the control bundle of the arithmetic unit.
// ============================================================================
package qbt_pkg;

    localparam int MAX_SEGMENTS_DEF = 63;
    localparam int COORD_BITS_DEF   = 32;
    localparam int SEG_BITS         = 6;

    typedef struct packed {
        logic mac_first;
        logic mac;
        logic div_load;
        logic div_step;
    } t_arith_ctl;

endpackage

>>> src/qbt_arith.sv
// ============================================================================
// Shared multiply-accumulate and divide unit
// Accumulates three weighted control coordinates, then divides the biased
// sum by twice the segment count squared, one quotient bit per cycle.
// ============================================================================
module qbt_arith #(
    parameter int COORD_BITS  = 32,
    parameter int WEIGHT_BITS = 12
) (
    input  logic                          i_clk,
    input  qbt_pkg::t_arith_ctl           i_ctl,
    input  logic signed [COORD_BITS-1:0]  i_coef,
    input  logic [WEIGHT_BITS-1:0]        i_weight,
    input  logic [WEIGHT_BITS-1:0]        i_d,
    output logic [COORD_BITS-1:0]         o_quot
);
    import qbt_pkg::*;

    localparam int PW = COORD_BITS + WEIGHT_BITS + 1;
    localparam int NW = COORD_BITS + WEIGHT_BITS + 2;
    localparam int RW = WEIGHT_BITS + 1;

    logic signed [PW-1:0] prod;
    logic signed [NW-1:0] term;
    logic signed [NW-1:0] bias;
    logic [RW:0]          trial;
    logic [RW:0]          divisor;
    logic [RW:0]          diff;
    logic                 fits;

    logic signed [NW-1:0] r_acc;
    logic [RW-1:0]        r_rem;

    assign prod    = PW'(i_coef) * PW'($signed({1'b0, i_weight}));
    assign term    = {prod, 1'b0};
    assign bias    = $signed({{(NW-WEIGHT_BITS){1'b0}}, i_d})
                   + $signed({2'b00, i_d, {COORD_BITS{1'b0}}});
    assign trial   = {r_rem, r_acc[COORD_BITS-1]};
    assign divisor = {1'b0, i_d, 1'b0};
    assign fits    = (trial >= divisor);
    assign diff    = trial - divisor;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mac_first) begin
            r_acc <= bias + term;
        end else if (i_ctl.mac) begin
            r_acc <= r_acc + term;
        end else if (i_ctl.div_step) begin
            r_acc[COORD_BITS-1:0] <= {r_acc[COORD_BITS-2:0], fits};
        end
        if (i_ctl.div_load) begin
            r_rem <= r_acc[NW-2:COORD_BITS];
        end else if (i_ctl.div_step) begin
            r_rem <= fits ? diff[RW-1:0] : trial[RW-1:0];
        end
    end

    // The sum was biased by half the coordinate range; undo it on the quotient.
    assign o_quot = {~r_acc[COORD_BITS-1], r_acc[COORD_BITS-2:0]};

endmodule

>>> src/quadratic_bezier_tessellator_unit.sv
// ============================================================================
// Quadratic curve tessellator
// Samples one quadratic curve at n+1 evenly spaced points.
// ============================================================================
// A curve request carries three control points in signed fixed point and a
// segment count n; a count of zero is taken as one and a count above
// MAX_SEGMENTS as MAX_SEGMENTS. The input channel is accepted on i_valid
// with o_stall low; o_stall stays high from acceptance until the last point
// of the curve has been taken. Points leave on o_valid with i_stall low, in
// rising order of point number, the final one flagged by o_last_point.
// Each coordinate is one pass of a shared multiplier over the three control
// points, then a restoring divider giving one quotient bit per cycle; the
// x, y and z coordinates of a point are worked in turn, and the finished
// point is presented from output registers.
// While i_stall is high the finished point holds on the outputs and the
// unit waits. Reset returns the unit to idle and drops o_valid.
// ============================================================================
module quadratic_bezier_tessellator_unit #(
    parameter int MAX_SEGMENTS = qbt_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = qbt_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_BITS-1:0]        i_start_x,
    input  logic signed [COORD_BITS-1:0]        i_start_y,
    input  logic signed [COORD_BITS-1:0]        i_start_z,
    input  logic signed [COORD_BITS-1:0]        i_ctrl_x,
    input  logic signed [COORD_BITS-1:0]        i_ctrl_y,
    input  logic signed [COORD_BITS-1:0]        i_ctrl_z,
    input  logic signed [COORD_BITS-1:0]        i_end_x,
    input  logic signed [COORD_BITS-1:0]        i_end_y,
    input  logic signed [COORD_BITS-1:0]        i_end_z,
    input  logic [qbt_pkg::SEG_BITS-1:0]        i_segment_count,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [COORD_BITS-1:0]        o_point_x,
    output logic signed [COORD_BITS-1:0]        o_point_y,
    output logic signed [COORD_BITS-1:0]        o_point_z,
    output logic [qbt_pkg::SEG_BITS-1:0]        o_point_number,
    output logic                                o_last_point
);
    import qbt_pkg::*;

    localparam int WW = $clog2(MAX_SEGMENTS * MAX_SEGMENTS + 1);
    localparam int AW = WW + SEG_BITS + 2;
    localparam int SW = $clog2(COORD_BITS);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SETUP = 7'b0000010,
        ST_MAC   = 7'b0000100,
        ST_DLOAD = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_SAVE  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic signed [COORD_BITS-1:0] r_pt [3][3];
    logic signed [COORD_BITS-1:0] r_res [3];
    logic [SEG_BITS-1:0]          r_n;
    logic [SEG_BITS-1:0]          r_idx;
    logic [WW-1:0]                r_d;
    logic [WW-1:0]                r_a;
    logic [WW-1:0]                r_c;
    logic [1:0]                   r_term;
    logic [1:0]                   r_coord;
    logic [SW-1:0]                r_step;

    logic [SEG_BITS-1:0]          seg_sat;
    logic [WW-1:0]                w_b2;
    logic [WW-1:0]                weight;
    logic [AW-1:0]                a_upd;
    logic [AW-1:0]                c_upd;
    logic [2*SEG_BITS-1:0]        n_sq;
    logic                         last_idx;
    logic [COORD_BITS-1:0]        quot;
    t_arith_ctl                   ctl;

    always_comb begin
        if (i_segment_count == '0) begin
            seg_sat = SEG_BITS'(1);
        end else if (i_segment_count > SEG_BITS'(MAX_SEGMENTS)) begin
            seg_sat = SEG_BITS'(MAX_SEGMENTS);
        end else begin
            seg_sat = i_segment_count;
        end
    end

    assign n_sq     = (2*SEG_BITS)'(r_n) * (2*SEG_BITS)'(r_n);
    assign w_b2     = r_d - r_a - r_c;
    assign a_upd    = AW'(r_a) + AW'(1) - AW'({r_n - r_idx, 1'b0});
    assign c_upd    = AW'(r_c) + AW'({r_idx, 1'b1});
    assign last_idx = (r_idx == r_n);

    always_comb begin
        case (r_term)
            2'd0: weight = r_a;
            2'd1: weight = w_b2;
            default: weight = r_c;
        endcase
    end

    always_comb begin
        ctl           = '0;
        ctl.mac_first = (r_state == ST_MAC) && (r_term == 2'd0);
        ctl.mac       = (r_state == ST_MAC) && (r_term != 2'd0);
        ctl.div_load  = (r_state == ST_DLOAD);
        ctl.div_step  = (r_state == ST_DIV);
    end

    qbt_arith #(
        .COORD_BITS  (COORD_BITS),
        .WEIGHT_BITS (WW)
    ) u_arith (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_coef   (r_pt[r_term][r_coord]),
        .i_weight (weight),
        .i_d      (r_d),
        .o_quot   (quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_MAC;
            ST_MAC: begin
                if (r_term == 2'd2) begin
                    n_state = ST_DLOAD;
                end
            end
            ST_DLOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == SW'(COORD_BITS - 1)) begin
                    n_state = ST_SAVE;
                end
            end
            ST_SAVE: begin
                n_state = (r_coord == 2'd2) ? ST_OUT : ST_MAC;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = last_idx ? ST_IDLE : ST_MAC;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_pt[0][0] <= i_start_x;
                r_pt[0][1] <= i_start_y;
                r_pt[0][2] <= i_start_z;
                r_pt[1][0] <= i_ctrl_x;
                r_pt[1][1] <= i_ctrl_y;
                r_pt[1][2] <= i_ctrl_z;
                r_pt[2][0] <= i_end_x;
                r_pt[2][1] <= i_end_y;
                r_pt[2][2] <= i_end_z;
                r_n        <= seg_sat;
            end
            ST_SETUP: begin
                r_d     <= WW'(n_sq);
                r_a     <= WW'(n_sq);
                r_c     <= '0;
                r_idx   <= '0;
                r_term  <= 2'd0;
                r_coord <= 2'd0;
            end
            ST_MAC: begin
                if (r_term != 2'd2) begin
                    r_term <= r_term + 2'd1;
                end
            end
            ST_DLOAD: begin
                r_step <= '0;
            end
            ST_DIV: begin
                r_step <= r_step + SW'(1);
            end
            ST_SAVE: begin
                r_res[r_coord] <= $signed(quot);
                r_coord        <= (r_coord == 2'd2) ? 2'd0 : r_coord + 2'd1;
                r_term         <= 2'd0;
            end
            ST_OUT: begin
                if (!i_stall && !last_idx) begin
                    r_idx   <= r_idx + SEG_BITS'(1);
                    r_a     <= a_upd[WW-1:0];
                    r_c     <= c_upd[WW-1:0];
                    r_coord <= 2'd0;
                    r_term  <= 2'd0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = (r_state == ST_OUT);
    assign o_point_x      = r_res[0];
    assign o_point_y      = r_res[1];
    assign o_point_z      = r_res[2];
    assign o_point_number = r_idx;
    assign o_last_point   = last_idx;

endmodule
